FILE: rtl/heat_equation_explicit_1d_unit_macros.svh
// assertion macros for the 1-d explicit heat equation unit
// expects signals named clock and reset in the module that uses them
`ifndef HEAT_EQUATION_EXPLICIT_1D_UNIT_MACROS_SVH
`define HEAT_EQUATION_EXPLICIT_1D_UNIT_MACROS_SVH

// condition holds in the same cycle
`define HEQ_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define HEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/heq_pkg.sv
// shared types and constants for the 1-d explicit heat equation unit
// no dependencies
`timescale 1ns / 1ps

package heq_pkg;

   localparam int GRID_POINTS = 256;
   // ring holds the grid plus two spare cells so stencil write-back ends inside a pass
   localparam int RING_CELLS  = GRID_POINTS + 2;
   localparam int PTR_W       = $clog2(RING_CELLS);
   localparam int COUNT_W     = $clog2(GRID_POINTS + 1);
   localparam int RDPTR_W     = $clog2(GRID_POINTS);

   localparam int DATA_W      = 32;
   localparam int RATIO_W     = 16;
   localparam int STEPS_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int FRAC_W      = 16;
   localparam int LAP_W       = DATA_W + 3;
   localparam int PROD_W      = LAP_W + RATIO_W + 1;
   localparam int SHIFT_W     = PROD_W - FRAC_W;

   // fixed cells hit by the stencil write-back, as the center's result leaves prod_ff
   localparam int WB_MID_CELL    = RING_CELLS - 3;
   localparam int WB_BEFORE_CELL = RING_CELLS - 4;
   localparam int WB_AFTER_CELL  = RING_CELLS - 2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6554;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd2000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIFFUSION_RATIO = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_COUNT      = 1'd1;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type DATA_MAX = 32'sh7fffffff;
   localparam data_type DATA_MIN = 32'sh80000000;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_STEP
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ZERO,
      ACT_READ,
      ACT_LOAD,
      ACT_FINAL,
      ACT_RUN
   } act_type;

   typedef struct packed {
      logic valid;
      logic first_int;
      logic last_int;
   } stencil_ctl_type;

   typedef struct packed {
      logic wr_mid;
      logic wr_before;
      logic wr_after;
   } stencil_wb_type;

endpackage

FILE: rtl/heq_cell.sv
// one storage cell of the grid ring: shifts toward cell 0, or takes an override word
// depends on heq_pkg
`timescale 1ns / 1ps

module heq_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  heq_pkg::data_type neighbor_value,
   input  logic             alt_sel,
   input  heq_pkg::data_type alt_value,
   output heq_pkg::data_type value
);
   import heq_pkg::*;

   data_type value_ff;
   data_type value_in;

   always_comb begin
      value_in = alt_sel ? alt_value : neighbor_value;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

FILE: rtl/heq_stencil.sv
// three-point ftcs stencil pipeline: laplacian, multiply by sigma, round and saturate
// depends on heq_pkg
`timescale 1ns / 1ps

module heq_stencil (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [heq_pkg::RATIO_W-1:0]  ratio,
   input  heq_pkg::stencil_ctl_type     ctl,
   input  heq_pkg::data_type            left_value,
   input  heq_pkg::data_type            mid_value,
   input  heq_pkg::data_type            right_value,
   output heq_pkg::stencil_wb_type      wb,
   output heq_pkg::data_type            result
);
   import heq_pkg::*;

   stencil_ctl_type          ctl1_ff, ctl1_in;
   stencil_ctl_type          ctl2_ff, ctl2_in;
   logic signed [LAP_W-1:0]  lap_ff, lap_in;
   data_type                 mid1_ff, mid1_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   data_type                 mid2_ff, mid2_in;
   logic signed [RATIO_W:0]  ratio_s;
   logic signed [PROD_W-1:0] sum;
   logic signed [SHIFT_W-1:0] shifted;

   // stage 1: left + right - 2*mid
   always_comb begin
      lap_in = {{3{left_value[DATA_W-1]}}, left_value}
             + {{3{right_value[DATA_W-1]}}, right_value}
             - {{2{mid_value[DATA_W-1]}}, mid_value, 1'b0};
      mid1_in = mid_value;
      ctl1_in = ctl;
   end

   // stage 2: sigma * lap
   always_comb begin
      ratio_s = {1'b0, ratio};
      prod_in = ratio_s * lap_ff;
      mid2_in = mid1_ff;
      ctl2_in = ctl1_ff;
   end

   // mid + floor((prod + half) / 2^16) folded into one add
   always_comb begin
      sum     = prod_ff + {{4{mid2_ff[DATA_W-1]}}, mid2_ff, {FRAC_W{1'b0}}} + ROUND_HALF;
      shifted = sum[PROD_W-1:FRAC_W];
      if ((&shifted[SHIFT_W-1:DATA_W-1]) || !(|shifted[SHIFT_W-1:DATA_W-1])) begin
         result = shifted[DATA_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         result = DATA_MIN;
      end else begin
         result = DATA_MAX;
      end
      wb.wr_mid    = ctl2_ff.valid;
      wb.wr_before = ctl2_ff.valid && ctl2_ff.first_int;
      wb.wr_after  = ctl2_ff.valid && ctl2_ff.last_int;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      lap_ff  <= lap_in;
      mid1_ff <= mid1_in;
      prod_ff <= prod_in;
      mid2_ff <= mid2_in;
   end

endmodule

FILE: rtl/heat_equation_explicit_1d_unit.sv
// top level of the 1-d explicit heat equation unit: control, grid ring, stencil
// depends on heq_pkg, heq_cell, heq_stencil and the assertion macro header
`timescale 1ns / 1ps
`include "heat_equation_explicit_1d_unit_macros.svh"

// Usage
// A command word is taken when start is high and busy is low. opcode load appends
// req_sample to the grid; a load with req_final_load set starts the run, which applies
// step_count ftcs steps with zero-gradient ends. opcode read returns the next grid point
// on rsp_value / rsp_last_point with rsp_valid high for one cycle, registered.
// rsp_valid cannot be held off; the receiver takes every word as it comes.
// The grid lives in a ring of GRID_POINTS+2 cells that rotates toward cell 0; every
// access waits until the wanted point sits in cell 0. Back-to-back loads and in-order
// reads therefore need no wait for rotation; a read that wraps, or the first access after
// a run, may wait while the ring rotates round. A run first rotates the ring into
// alignment, then makes one full ring pass per step, with busy high throughout.
// csr_we writes diffusion_ratio (index 0) or step_count (index 1) in the same cycle;
// write only while busy is low and no read word is pending.
// Synchronous reset clears counters, flags and the registers to their defaults; grid
// contents are undefined until loaded.

module heat_equation_explicit_1d_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  heq_pkg::data_type                 req_sample,
   input  logic                              req_final_load,
   output logic                              rsp_valid,
   output heq_pkg::data_type                 rsp_value,
   output logic                              rsp_last_point,
   input  logic                              csr_we,
   input  logic [heq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [heq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import heq_pkg::*;

   state_type             state_ff, state_in;
   act_type               pend_ff, pend_in;
   logic [PTR_W-1:0]      rot_ff, rot_in;
   logic [PTR_W-1:0]      target_ff, target_in;
   data_type              pend_sample_ff, pend_sample_in;
   logic                  pend_final_ff, pend_final_in;
   logic [COUNT_W-1:0]    points_ff, points_in;
   logic [RDPTR_W-1:0]    rdptr_ff, rdptr_in;
   logic                  ready_ff, ready_in;
   logic [PTR_W-1:0]      pass_ff, pass_in;
   logic [STEPS_W-1:0]    stepc_ff, stepc_in;
   data_type              saved_ff, saved_in;
   logic [RATIO_W-1:0]    ratio_ff, ratio_in;
   logic [STEPS_W-1:0]    steps_ff, steps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   data_type              rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   // decode of the current action
   logic                  accept;
   act_type               act;
   logic [PTR_W-1:0]      act_target;
   data_type              act_sample;
   logic                  act_final;
   logic [COUNT_W-1:0]    points_eff;
   logic [COUNT_W-1:0]    points_after;
   logic [COUNT_W-1:0]    rdptr_wide;
   logic                  aligned;
   logic                  clear_grid;
   logic                  load_done;
   logic                  want_run;
   logic                  run_go;
   logic [PTR_W:0]        tgt_next;
   logic [PTR_W:0]        points_cmp;
   logic [PTR_W:0]        pass_next;
   logic                  read_last;
   logic                  pass_end;
   logic                  run_end;

   // ring and stencil
   data_type              cell_q [RING_CELLS];
   data_type              tail_value;
   logic                  rotate;
   logic [RING_CELLS-1:0] alt_sel;
   stencil_ctl_type       sten_ctl;
   stencil_wb_type        sten_wb;
   data_type              sten_result;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      rdptr_wide = COUNT_W'(rdptr_ff);
      points_eff = points_ff;
      clear_grid = 1'b0;
      act        = ACT_NONE;
      act_target = target_ff;
      act_sample = pend_sample_ff;
      act_final  = pend_final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_sample = req_sample;
               act_final  = req_final_load;
               if (req_opcode == OP_READ) begin
                  if (points_ff == '0) begin
                     act = ACT_ZERO;
                  end else begin
                     act = ACT_READ;
                     act_target = (rdptr_wide >= points_ff) ? '0 : PTR_W'(rdptr_ff);
                  end
               end else begin
                  // a load after a finished run begins a new grid
                  if (ready_ff) begin
                     clear_grid = 1'b1;
                     points_eff = '0;
                  end
                  if (points_eff < COUNT_W'(GRID_POINTS)) begin
                     act        = ACT_LOAD;
                     act_target = PTR_W'(points_eff);
                  end else begin
                     act = ACT_FINAL;
                  end
               end
            end
         end
         ST_SEEK: begin
            act = pend_ff;
         end
         ST_STEP: begin
            act = ACT_NONE;
         end
         default: begin
            act = ACT_NONE;
         end
      endcase

      aligned      = (rot_ff == act_target);
      load_done    = ((act == ACT_LOAD) && aligned) || (act == ACT_FINAL);
      points_after = ((act == ACT_LOAD) && aligned) ? points_eff + 1'b1 : points_eff;
      want_run     = load_done && act_final;
      run_go       = (points_after >= COUNT_W'(3)) && (steps_ff != '0);
      tgt_next     = {1'b0, act_target} + 1'b1;
      points_cmp   = (PTR_W + 1)'(points_ff);
      read_last    = (tgt_next >= points_cmp);
      pass_end     = (pass_ff == PTR_W'(RING_CELLS - 1));
      run_end      = pass_end && ((STEPS_W + 1)'(stepc_ff) + 1'b1 == (STEPS_W + 1)'(steps_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if ((act == ACT_READ || act == ACT_LOAD) && !aligned) begin
               state_in = ST_SEEK;
            end else if (want_run && run_go) begin
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (aligned) begin
               if (act == ACT_RUN) begin
                  state_in = ST_STEP;
               end else if (want_run && run_go) begin
                  state_in = ST_SEEK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STEP: begin
            if (run_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rotate         = (state_ff == ST_STEP) || (act == ACT_READ) || (act == ACT_LOAD)
                    || ((act == ACT_RUN) && !aligned);
      tail_value     = ((act == ACT_LOAD) && aligned) ? act_sample : cell_q[0];
      rot_in         = rot_ff;
      if (rotate && (state_ff != ST_STEP)) begin
         rot_in = (rot_ff == PTR_W'(RING_CELLS - 1)) ? '0 : rot_ff + 1'b1;
      end

      pend_in        = pend_ff;
      target_in      = target_ff;
      pend_sample_in = pend_sample_ff;
      pend_final_in  = pend_final_ff;
      if (accept) begin
         pend_in        = act;
         target_in      = act_target;
         pend_sample_in = req_sample;
         pend_final_in  = req_final_load;
      end
      if (want_run && run_go) begin
         pend_in   = ACT_RUN;
         target_in = '0;
      end

      points_in = points_after;
      rdptr_in  = clear_grid ? '0 : rdptr_ff;
      ready_in  = clear_grid ? 1'b0 : ready_ff;
      if (want_run && !run_go) begin
         ready_in = 1'b1;
      end

      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (act == ACT_ZERO) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
      end else if ((act == ACT_READ) && aligned) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = cell_q[0];
         rsp_last_in  = read_last;
         rdptr_in     = read_last ? '0 : RDPTR_W'(tgt_next);
      end

      pass_in  = pass_ff;
      stepc_in = stepc_ff;
      saved_in = saved_ff;
      if ((act == ACT_RUN) && aligned) begin
         pass_in  = '0;
         stepc_in = '0;
      end
      if (state_ff == ST_STEP) begin
         saved_in = cell_q[0];
         pass_in  = pass_end ? '0 : pass_ff + 1'b1;
         if (pass_end) begin
            stepc_in = stepc_ff + 1'b1;
         end
         if (run_end) begin
            ready_in = 1'b1;
         end
      end

      // interior points are 1 .. n-2 of each pass
      pass_next          = {1'b0, pass_ff} + 1'b1;
      sten_ctl.valid     = (state_ff == ST_STEP) && (pass_ff != '0) && (pass_next < points_cmp);
      sten_ctl.first_int = (pass_ff == PTR_W'(1));
      sten_ctl.last_int  = (pass_next + 1'b1 == points_cmp);

      alt_sel                 = '0;
      alt_sel[WB_MID_CELL]    = sten_wb.wr_mid;
      alt_sel[WB_BEFORE_CELL] = sten_wb.wr_before;
      alt_sel[WB_AFTER_CELL]  = sten_wb.wr_after;

      ratio_in = ratio_ff;
      steps_in = steps_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIFFUSION_RATIO: ratio_in = csr_wdata;
            CSR_STEP_COUNT:      steps_in = csr_wdata;
            default: begin
               ratio_in = ratio_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= ACT_NONE;
         rot_ff       <= '0;
         points_ff    <= '0;
         rdptr_ff     <= '0;
         ready_ff     <= 1'b0;
         pass_ff      <= '0;
         stepc_ff     <= '0;
         saved_ff     <= '0;
         ratio_ff     <= RATIO_RESET;
         steps_ff     <= STEPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rot_ff       <= rot_in;
         points_ff    <= points_in;
         rdptr_ff     <= rdptr_in;
         ready_ff     <= ready_in;
         pass_ff      <= pass_in;
         stepc_ff     <= stepc_in;
         saved_ff     <= saved_in;
         ratio_ff     <= ratio_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff      <= target_in;
      pend_sample_ff <= pend_sample_in;
      pend_final_ff  <= pend_final_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // grid ring: words move toward cell 0, cell 0 feeds back into the tail
   for (genvar k = 0; k < RING_CELLS; k++) begin : g_cell
      if (k == RING_CELLS - 1) begin : g_tail
         heq_cell u_cell (
            .clock          (clock),
            .shift_en       (rotate),
            .neighbor_value (tail_value),
            .alt_sel        (alt_sel[k]),
            .alt_value      (sten_result),
            .value          (cell_q[k])
         );
      end else begin : g_body
         heq_cell u_cell (
            .clock          (clock),
            .shift_en       (rotate),
            .neighbor_value (cell_q[k+1]),
            .alt_sel        (alt_sel[k]),
            .alt_value      (sten_result),
            .value          (cell_q[k])
         );
      end
   end

   heq_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .ratio       (ratio_ff),
      .ctl         (sten_ctl),
      .left_value  (saved_ff),
      .mid_value   (cell_q[0]),
      .right_value (cell_q[1]),
      .wb          (sten_wb),
      .result      (sten_result)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_last_point = rsp_last_ff;

   `HEQ_ASSERT_NEXT(a_no_word_while_stepping, state_ff == ST_STEP, !rsp_valid_ff, "read word during run")
   `HEQ_ASSERT_HOLDS(a_ring_home_while_stepping, state_ff == ST_STEP, rot_ff == '0, "ring not aligned during run")
   `HEQ_ASSERT_HOLDS(a_rdptr_in_grid, points_ff != '0, rdptr_wide < points_ff, "read pointer beyond grid")
   `HEQ_ASSERT_HOLDS(a_writeback_in_run, sten_wb.wr_mid || sten_wb.wr_before || sten_wb.wr_after, state_ff == ST_STEP, "stencil write outside run")

endmodule

FILE: bench/heat_equation_explicit_1d_unit_tb.sv
// self-checking bench for the 1-d explicit heat equation unit
// drives load/read command words with random gaps and checks every read word against
// an in-bench ftcs predictor; depends on heq_pkg and heat_equation_explicit_1d_unit
`timescale 1ns / 1ps

module heat_equation_explicit_1d_unit_tb;
   import heq_pkg::*;

   typedef struct {
      logic     op;
      data_type sample;
      logic     fin;
      bit       hold_off;
   } cmd_word_t;

   typedef struct {
      data_type value;
      logic     last;
   } grid_point_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_opcode = OP_LOAD;
   data_type               req_sample = '0;
   logic                   req_final_load = 1'b0;
   logic                   rsp_valid;
   data_type               rsp_value;
   logic                   rsp_last_point;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DIFFUSION_RATIO;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   heat_equation_explicit_1d_unit uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_sample     (req_sample),
      .req_final_load (req_final_load),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_last_point (rsp_last_point),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   data_type        grid_model [GRID_POINTS];
   int              pts_count;
   int              rd_ptr;
   bit              run_done;
   logic [15:0]     ratio_q;
   int unsigned     steps_q;

   cmd_word_t       word_q [$];
   grid_point_t     point_q [$];
   int              gen_cnt = 0;
   int              acc_cnt = 0;
   int              errors = 0;
   int              gap_left = 0;
   bit              no_idle = 0;
   logic            took_word = 1'b0;
   cmd_word_t       drv_word;

   // in-place ftcs sweep with zero-gradient ends
   function automatic void diffuse_grid();
      longint signed left, mid, right, lap, acc, nv, r;
      data_type      keep;
      int            n;
      n = pts_count;
      r = ratio_q;
      if (n < 3) return;
      for (int unsigned s = 0; s < steps_q; s++) begin
         keep = grid_model[0];
         for (int i = 1; i + 1 < n; i++) begin
            left  = keep;
            mid   = grid_model[i];
            right = grid_model[i + 1];
            lap   = left + right - 2 * mid;
            acc   = (r * lap + 32768) >>> 16;
            keep  = grid_model[i];
            nv    = mid + acc;
            if (nv > longint'(DATA_MAX)) nv = DATA_MAX;
            if (nv < longint'(DATA_MIN)) nv = DATA_MIN;
            grid_model[i] = nv[31:0];
         end
         grid_model[0]     = grid_model[1];
         grid_model[n - 1] = grid_model[n - 2];
      end
   endfunction

   function automatic void predict_word(logic op, data_type sample, logic fin);
      grid_point_t p;
      if (op == OP_LOAD) begin
         if (run_done) begin
            pts_count = 0;
            rd_ptr    = 0;
            run_done  = 0;
         end
         if (pts_count < GRID_POINTS) begin
            grid_model[pts_count] = sample;
            pts_count++;
         end
         if (fin) begin
            diffuse_grid();
            run_done = 1;
         end
      end else begin
         if (pts_count == 0) begin
            p.value = '0;
            p.last  = 1'b1;
         end else begin
            if (rd_ptr >= pts_count) rd_ptr = 0;
            p.value = grid_model[rd_ptr];
            p.last  = (rd_ptr + 1 >= pts_count);
            rd_ptr  = p.last ? 0 : rd_ptr + 1;
         end
         point_q.push_back(p);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver: next word goes out at the falling edge once the current one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !took_word)) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (word_q.size() > 0 && !(word_q[0].hold_off && point_q.size() != 0)) begin
            drv_word = word_q.pop_front();
            req_opcode     <= drv_word.op;
            req_sample     <= drv_word.sample;
            req_final_load <= drv_word.fin;
            start          <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // acceptance and register tracking
   always @(posedge clock) begin
      took_word <= !reset && start && !busy;
      if (reset) begin
         pts_count = 0;
         rd_ptr    = 0;
         run_done  = 0;
         ratio_q   = RATIO_RESET;
         steps_q   = STEPS_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DIFFUSION_RATIO) ratio_q = csr_wdata;
            else if (csr_index == CSR_STEP_COUNT) steps_q = csr_wdata;
         end
         if (start && !busy) begin
            predict_word(req_opcode, req_sample, req_final_load);
            acc_cnt++;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      grid_point_t p;
      if (!reset && rsp_valid) begin
         if (point_q.size() == 0) begin
            $error("unexpected read word: rsp_value %h rsp_last_point %b",
                   rsp_value, rsp_last_point);
            errors++;
         end else begin
            p = point_q.pop_front();
            if (rsp_value !== p.value) begin
               $error("rsp_value: expected %h, got %h", p.value, rsp_value);
               errors++;
            end
            if (rsp_last_point !== p.last) begin
               $error("rsp_last_point: expected %b, got %b", p.last, rsp_last_point);
               errors++;
            end
         end
      end
   end

   task automatic push_word(logic op, data_type sample, logic fin);
      cmd_word_t w;
      w.op       = op;
      w.sample   = sample;
      w.fin      = fin;
      w.hold_off = ($urandom_range(0, 39) == 0);
      word_q.push_back(w);
      gen_cnt++;
   endtask

   // read ignores final_load, so it is toggled as noise
   task automatic push_read();
      push_word(OP_READ, $urandom, ($urandom_range(0, 3) == 0));
   endtask

   function automatic data_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return '0;
         3, 4:    return $urandom;
         default: return data_type'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 40);
      return $urandom_range(41, 120);
   endfunction

   // pushes k loads (reads mixed in), the last flagged final if with_run, then reads
   task automatic push_grid(int k, bit with_run, int reads);
      for (int j = 0; j < k; j++) begin
         if ($urandom_range(0, 9) == 0) push_read();
         push_word(OP_LOAD, rand_sample(), with_run && (j == k - 1));
      end
      for (int j = 0; j < reads; j++) push_read();
   endtask

   task automatic wait_quiet();
      do @(negedge clock); while (acc_cnt != gen_cnt || point_q.size() != 0);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(logic [15:0] ratio, logic [15:0] steps);
      wait_quiet();
      csr_write(CSR_DIFFUSION_RATIO, ratio);
      csr_write(CSR_STEP_COUNT, steps);
   endtask

   initial begin
      int rand_base, phase, k, r;
      logic [15:0] ratio, steps;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      set_config(16'hffff, 16'd3);
      push_word(OP_READ, '0, 1'b0);            // empty grid
      push_word(OP_READ, DATA_MAX, 1'b1);
      push_word(OP_LOAD, DATA_MAX, 1'b0);
      push_word(OP_LOAD, DATA_MIN, 1'b0);
      push_word(OP_READ, '0, 1'b0);            // read before the run
      push_word(OP_LOAD, 32'sh0001_0000, 1'b1);
      repeat (4) push_word(OP_READ, '0, 1'b0); // wraps to the start
      push_word(OP_LOAD, 32'sh1234_5678, 1'b1); // one-point grid
      repeat (2) push_word(OP_READ, '0, 1'b0);
      push_word(OP_LOAD, 32'shedcb_a987, 1'b0);
      push_word(OP_LOAD, -32'sd1, 1'b1);        // two-point grid
      repeat (2) push_word(OP_READ, '0, 1'b0);
      push_word(OP_LOAD, 32'sh5555_5555, 1'b0);
      push_word(OP_LOAD, 32'shaaaa_aaaa, 1'b0);
      push_word(OP_LOAD, '0, 1'b1);
      repeat (3) push_word(OP_READ, '0, 1'b0);

      rand_base = gen_cnt;
      phase = 0;
      while (gen_cnt - rand_base < 550) begin
         case (phase)
            0: begin
               // loads past capacity are dropped but the final flag still runs
               set_config($urandom, 16'd1);
               push_grid(GRID_POINTS + $urandom_range(1, 4), 1, 12);
            end
            1: begin
               set_config(16'd0, 16'd0);
               push_grid(5, 1, 7);
               push_grid(pick_size(), 1, $urandom_range(1, 10));
            end
            3: begin
               // longest step count only with loads that never start a run
               set_config(16'h8000, 16'hffff);
               repeat (3) push_read();
               push_grid(pick_size(), 0, $urandom_range(1, 12));
            end
            default: begin
               case ($urandom_range(0, 4))
                  0:       ratio = 16'd0;
                  1:       ratio = 16'hffff;
                  2:       ratio = 16'h8000;
                  3:       ratio = RATIO_RESET;
                  default: ratio = $urandom;
               endcase
               r = $urandom_range(0, 99);
               if (r < 20)      steps = 16'd0;
               else if (r < 40) steps = 16'd1;
               else if (r < 80) steps = $urandom_range(2, 8);
               else             steps = $urandom_range(9, 40);
               if (phase == 2) ratio = 16'hffff;
               set_config(ratio, steps);
               no_idle = ($urandom_range(0, 4) == 0);
               repeat ($urandom_range(2, 5)) begin
                  r = $urandom_range(0, 99);
                  k = pick_size();
                  if (r < 80)      push_grid(k, 1, $urandom_range(1, (k < 20) ? 2 * k + 1 : 20));
                  else if (r < 92) push_grid(k, 0, $urandom_range(1, k + 2));
                  else             repeat ($urandom_range(1, 6)) push_read();
               end
               no_idle = 0;
            end
         endcase
         phase++;
      end

      wait_quiet();
      repeat (GRID_POINTS + 2) @(negedge clock);
      if (point_q.size() != 0) begin
         $error("%0d read words never arrived", point_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("heat_equation_explicit_1d_unit test passed");
      end else begin
         $display("heat_equation_explicit_1d_unit test failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("heat_equation_explicit_1d_unit test failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/heq_pkg.sv
rtl/heq_cell.sv
rtl/heq_stencil.sv
rtl/heat_equation_explicit_1d_unit.sv
bench/heat_equation_explicit_1d_unit_tb.sv
